### hdl/dlp_pkg.sv
// shared types, constants and helpers for the duration list parser
// no dependencies; imported by every module of the block
package dlp_pkg;

  localparam int MAX_TIME_FIELDS = 3;
  localparam int VALUE_WIDTH     = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int PREFIX_LEN      = 10;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_ITEM  = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } field_phase_t;

  // up to two results caused by one input beat
  typedef struct packed {
    logic [OUT_WIDTH-1:0] value;
    logic [1:0]           kind_a;
    logic                 two;
    logic [1:0]           kind_b;
  } dlp_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dlp_qstat_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h64; // d
      4'd1:    ch = 8'h75; // u
      4'd2:    ch = 8'h72; // r
      4'd3:    ch = 8'h61; // a
      4'd4:    ch = 8'h74; // t
      4'd5:    ch = 8'h69; // i
      4'd6:    ch = 8'h6f; // o
      4'd7:    ch = 8'h6e; // n
      4'd8:    ch = 8'h73; // s
      4'd9:    ch = 8'h3a; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // low output bits of a value, zero extended when the value is narrower
  function automatic logic [OUT_WIDTH-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[OUT_WIDTH-1:0];
  endfunction

endpackage

### hdl/dlp_front.sv
// front end: prefix check, item and field parsing, result classification
// depends on dlp_pkg
module dlp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       char_in,
  input  logic             end_of_text,
  output logic             rec_valid,
  output dlp_pkg::dlp_rec_t rec
);
  import dlp_pkg::*;

  logic [3:0]             prefix_position, prefix_position_next;
  logic                   discarding, discarding_next;
  logic [1:0]             item_length_sat, item_length_sat_next;
  logic                   item_opened_by_quote, item_opened_by_quote_next;
  logic                   previous_was_quote, previous_was_quote_next;
  logic [1:0]             colon_count, colon_count_next;
  field_phase_t           field_phase, field_phase_next;
  logic                   field_negative, field_negative_next;
  logic [VALUE_WIDTH-1:0] field_magnitude, field_magnitude_next;
  logic [VALUE_WIDTH-1:0] seconds_so_far, seconds_so_far_next;

  logic [VALUE_WIDTH-1:0] field_value;
  logic [VALUE_WIDTH-1:0] fold;
  logic                   is_digit;
  logic                   is_space;
  logic                   close_ok;
  logic                   failed;
  logic                   item_emit;
  logic                   end_ok;

  // seconds*60 + signed field, wrapping
  assign field_value = field_negative ? (VALUE_WIDTH'(0) - field_magnitude) : field_magnitude;
  assign fold = (seconds_so_far << 6) - (seconds_so_far << 2) + field_value;

  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_space = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
  assign close_ok = (item_length_sat == 2'd2) && item_opened_by_quote && previous_was_quote;

  always_comb begin
    prefix_position_next      = prefix_position;
    discarding_next           = discarding;
    item_length_sat_next      = item_length_sat;
    item_opened_by_quote_next = item_opened_by_quote;
    previous_was_quote_next   = previous_was_quote;
    colon_count_next          = colon_count;
    field_phase_next          = field_phase;
    field_negative_next       = field_negative;
    field_magnitude_next      = field_magnitude;
    seconds_so_far_next       = seconds_so_far;
    failed    = 1'b0;
    item_emit = 1'b0;
    end_ok    = 1'b0;
    rec_valid = 1'b0;
    rec       = '0;

    if (accept && !discarding) begin
      if (prefix_position < 4'(PREFIX_LEN)) begin
        if ((char_in != prefix_char(prefix_position)) || end_of_text) begin
          failed = 1'b1;
        end else begin
          prefix_position_next = prefix_position + 4'd1;
        end
      end else begin
        if (char_in == CH_COMMA) begin
          if (close_ok) begin
            item_emit                 = 1'b1;
            item_length_sat_next      = 2'd0;
            item_opened_by_quote_next = 1'b0;
            previous_was_quote_next   = 1'b0;
            colon_count_next          = 2'd0;
            seconds_so_far_next       = '0;
            field_phase_next          = PH_SKIP;
            field_negative_next       = 1'b0;
            field_magnitude_next      = '0;
          end else begin
            failed = 1'b1;
          end
        end else if (item_length_sat == 2'd0) begin
          if (char_in != CH_QUOTE) begin
            failed = 1'b1;
          end else begin
            item_length_sat_next      = 2'd1;
            item_opened_by_quote_next = 1'b1;
            previous_was_quote_next   = 1'b1;
          end
        end else begin
          if (item_length_sat != 2'd2) begin
            item_length_sat_next = item_length_sat + 2'd1;
          end
          previous_was_quote_next = (char_in == CH_QUOTE);
          if (char_in == CH_COLON) begin
            if ((3'(colon_count) + 3'd1) >= 3'(MAX_TIME_FIELDS)) begin
              failed = 1'b1;
            end else begin
              seconds_so_far_next  = fold;
              colon_count_next     = colon_count + 2'd1;
              field_phase_next     = PH_SKIP;
              field_negative_next  = 1'b0;
              field_magnitude_next = '0;
            end
          end else if ((field_phase == PH_SKIP) && is_space) begin
            field_phase_next = PH_SKIP;
          end else if ((field_phase == PH_SKIP) &&
                       ((char_in == CH_PLUS) || (char_in == CH_MINUS))) begin
            field_negative_next = (char_in == CH_MINUS);
            field_phase_next    = PH_DIGITS;
          end else if ((field_phase != PH_DONE) && is_digit) begin
            field_magnitude_next = (field_magnitude << 3) + (field_magnitude << 1)
                                   + VALUE_WIDTH'(char_in - CH_ZERO);
            field_phase_next     = PH_DIGITS;
          end else begin
            field_phase_next = PH_DONE;
          end
        end
        // a good close at the end needs a closing quote on this beat, which leaves
        // the fold unchanged, so the current fold serves
        if (!failed && end_of_text) begin
          if (!item_emit && (item_length_sat_next == 2'd2) && item_opened_by_quote_next
              && previous_was_quote_next) begin
            end_ok = 1'b1;
          end else begin
            failed = 1'b1;
          end
        end
      end

      if (item_emit || end_ok) begin
        rec.value  = to_out(fold);
        rec.kind_a = KIND_ITEM;
        rec.two    = failed || end_ok;
        rec.kind_b = failed ? KIND_ERROR : KIND_OK;
      end else begin
        rec.value  = '0;
        rec.kind_a = KIND_ERROR;
        rec.two    = 1'b0;
        rec.kind_b = KIND_ERROR;
      end
      rec_valid = item_emit || end_ok || failed;
      if (failed) begin
        discarding_next = 1'b1;
      end
    end

    if (accept && end_of_text) begin
      prefix_position_next      = 4'd0;
      discarding_next           = 1'b0;
      item_length_sat_next      = 2'd0;
      item_opened_by_quote_next = 1'b0;
      previous_was_quote_next   = 1'b0;
      colon_count_next          = 2'd0;
      seconds_so_far_next       = '0;
      field_phase_next          = PH_SKIP;
      field_negative_next       = 1'b0;
      field_magnitude_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_position      <= 4'd0;
      discarding           <= 1'b0;
      item_length_sat      <= 2'd0;
      item_opened_by_quote <= 1'b0;
      previous_was_quote   <= 1'b0;
      colon_count          <= 2'd0;
      field_phase          <= PH_SKIP;
      field_negative       <= 1'b0;
      field_magnitude      <= '0;
      seconds_so_far       <= '0;
    end else begin
      prefix_position      <= prefix_position_next;
      discarding           <= discarding_next;
      item_length_sat      <= item_length_sat_next;
      item_opened_by_quote <= item_opened_by_quote_next;
      previous_was_quote   <= previous_was_quote_next;
      colon_count          <= colon_count_next;
      field_phase          <= field_phase_next;
      field_negative       <= field_negative_next;
      field_magnitude      <= field_magnitude_next;
      seconds_so_far       <= seconds_so_far_next;
    end
  end

endmodule

### hdl/dlp_queue.sv
// short record queue between the parsing front end and the result back end
// depends on dlp_pkg
module dlp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  dlp_pkg::dlp_rec_t  wr_rec,
  input  logic               rd_en,
  output dlp_pkg::dlp_rec_t  head,
  output dlp_pkg::dlp_qstat_t stat
);
  import dlp_pkg::*;

  dlp_rec_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       count;
  logic                  do_wr;
  logic                  do_rd;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_wr = wr_en && !stat.full;
  assign do_rd = rd_en && !stat.empty;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/dlp_back.sv
// back end: unpacks queued records into single results for the output side
// depends on dlp_pkg
module dlp_back (
  input  logic                clk,
  input  logic                rst,
  input  dlp_pkg::dlp_rec_t   head,
  input  dlp_pkg::dlp_qstat_t stat,
  input  logic                pop,
  output logic                q_pop,
  output logic                empty,
  output logic signed [31:0]  seconds_value,
  output logic [1:0]          kind,
  output logic                last
);
  import dlp_pkg::*;

  // 0 on the first result of the head record, 1 on its second
  logic sub;

  assign empty         = stat.empty;
  assign kind          = sub ? head.kind_b : head.kind_a;
  assign seconds_value = sub ? 32'sd0 : signed'(32'(head.value));
  assign last          = sub || !head.two;
  assign q_pop         = pop && !stat.empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (pop && !stat.empty) begin
      sub <= !last;
    end
  end

endmodule

### hdl/duration_list_parser.sv
// Duration list parser, top level.
// Input side is a queue write port: a byte beat (char_in, end_of_text) is taken
// at a clock edge with push high and full low. The text must open with
// "durations:" followed by comma separated quoted hh:mm:ss items.
// Output side is a queue read port: while empty is low the oldest result sits
// on seconds_value/kind/last and leaves at an edge with pop high.
// kind 0 is a duration in seconds, 1 marks a good end of text, 2 an error;
// after an error bytes are dropped until end_of_text. last flags the final
// result caused by one input byte (a byte causes zero, one or two results).
// A result record is written into the queue at the edge that takes its byte.
// Throughput: one byte per cycle while full is low; the parser front end does
// all per-byte work combinationally, and a four-record queue separates it
// from the back end, which hands out one result per cycle of pop with empty low.
// When the receiver stalls the queue fills and full rises once four byte
// records are waiting; bytes with no results still need a free slot to pass.
// Synchronous reset clears the parser state and empties the queue.
// Depends on dlp_pkg, dlp_front, dlp_queue, dlp_back.
module duration_list_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_in,
  input  logic               end_of_text,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] seconds_value,
  output logic [1:0]         kind,
  output logic               last
);
  import dlp_pkg::*;

  logic       accept;
  logic       rec_valid;
  dlp_rec_t   rec;
  dlp_rec_t   head;
  dlp_qstat_t stat;
  logic       q_pop;

  assign full   = stat.full;
  assign accept = push && !stat.full;

  dlp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_in     (char_in),
    .end_of_text (end_of_text),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  dlp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (rec_valid),
    .wr_rec (rec),
    .rd_en  (q_pop),
    .head   (head),
    .stat   (stat)
  );

  dlp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .stat          (stat),
    .pop           (pop),
    .q_pop         (q_pop),
    .empty         (empty),
    .seconds_value (seconds_value),
    .kind          (kind),
    .last          (last)
  );

endmodule
